[rtl/core/lmsc_pkg.sv]
// Shared types, constants and pattern functions for the LED matrix scan controller.
// Used by every module under rtl/core; depends on nothing else.
package lmsc_pkg;

  localparam int MATRIX_SIZE_DEF = 8;
  localparam int MAX_SIZE        = 16;
  localparam int POS_W           = 5;   // holds a 1-based position plus glyph offset
  localparam int ROW_W           = 4;
  localparam int DWELL_W         = 16;
  localparam int GLYPH_ROWS      = 5;
  localparam int GLYPH_COLS      = 3;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_PIXEL  = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_DIGIT  = 3'd3,
    CMD_LETTER = 3'd4
  } lmsc_cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_SET,
    OP_CLEAR_PX,
    OP_BLANK,
    OP_LETTER
  } lmsc_op_kind_t;

  typedef struct packed {
    logic [2:0] command;
    logic       pixel_value;
    logic [3:0] column;
    logic [3:0] row;
    logic [3:0] digit;
    logic       letter;
  } lmsc_req_t;

  typedef struct packed {
    logic [7:0] row_select_n;
    logic [7:0] column_data;
    logic [2:0] scan_row;
  } lmsc_res_t;

  // Decoded request: masks[dy] lands on frame row (base_row + dy), 1-based.
  typedef struct packed {
    lmsc_op_kind_t                          kind;
    logic [ROW_W-1:0]                       base_row;
    logic [GLYPH_ROWS-1:0][MAX_SIZE-1:0]    masks;
    logic                                   letter;
  } lmsc_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lmsc_qstat_t;

  // 3x5 digit glyphs, top row in the high bits, left column first.
  function automatic logic [GLYPH_ROWS*GLYPH_COLS-1:0] glyph_bits(logic [3:0] d);
    logic [GLYPH_ROWS*GLYPH_COLS-1:0] g;
    case (d)
      4'd0:    g = 15'b111_101_101_101_111;
      4'd1:    g = 15'b001_011_001_001_001;
      4'd2:    g = 15'b111_001_111_100_111;
      4'd3:    g = 15'b111_001_111_001_111;
      4'd4:    g = 15'b101_101_111_001_001;
      4'd5:    g = 15'b111_100_111_001_111;
      4'd6:    g = 15'b111_100_111_101_111;
      4'd7:    g = 15'b111_001_001_001_001;
      4'd8:    g = 15'b111_101_111_101_111;
      4'd9:    g = 15'b111_101_111_001_111;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Row r (1-based) of the S (which = 0) or T (which = 1) image on an n x n matrix.
  function automatic logic [MAX_SIZE-1:0] letter_row(logic which, int r, int n);
    logic [MAX_SIZE-1:0] m;
    int                  col;
    logic                inner;
    m = '0;
    for (int b = 0; b < MAX_SIZE; b++) begin
      col   = n - b;
      inner = (col >= 2) && (col <= n - 1);
      if (b < n) begin
        if (!which) begin
          m[b] = ((r == 1 || r == 2 || r == 4 || r == 5 || r == 7 || r == 8) && inner) ||
                 (r == 3 && (col == 2 || col == 3)) ||
                 (r == 6 && (col == 6 || col == 7));
        end else begin
          m[b] = ((r == 2 || r == 3) && inner) ||
                 ((col == 4 || col == 5) && r >= 2 && r <= n - 1);
        end
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/led_matrix_scan_controller.sv]
// Top level of the LED matrix scan controller: front decoder, request queue, back end.
// Depends on lmsc_pkg, lmsc_front, lmsc_queue and lmsc_back.
//
//   Channel  Ports                        Transfer when
//   request  start, busy, in_req          start high and busy low
//   result   out_valid, out_res           out_valid high, one cycle, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// A request's result passes through the front register, the queue and the back
// end's result register.
// The back end retires one request per cycle, so a new request is taken every cycle while busy is low.
// busy rises only when the front register holds a request and the queue is full.
// Reset (rst_n low, synchronous) clears the frame buffer, the scan row and the
// dwell counter, and sets row_dwell to 1; cfg_ready is always high.
module led_matrix_scan_controller #(
  parameter int MATRIX_SIZE = lmsc_pkg::MATRIX_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lmsc_pkg::lmsc_req_t           in_req,
  output logic                          out_valid,
  output lmsc_pkg::lmsc_res_t           out_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lmsc_pkg::DWELL_W-1:0]  cfg_data
);

  lmsc_pkg::lmsc_qstat_t qstat;
  lmsc_pkg::lmsc_op_t    push_op;
  lmsc_pkg::lmsc_op_t    pop_op;
  logic                  push;
  logic                  pop;

  assign cfg_ready = 1'b1;

  lmsc_front #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .req     (in_req),
    .qstat   (qstat),
    .busy    (busy),
    .push    (push),
    .push_op (push_op)
  );

  lmsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .qstat   (qstat)
  );

  lmsc_back #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .op        (pop_op),
    .pop       (pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

[rtl/core/lmsc_front.sv]
// Front end: takes requests, decodes them into row masks and holds one for the queue.
// Depends on lmsc_pkg.
module lmsc_front #(
  parameter int MATRIX_SIZE = lmsc_pkg::MATRIX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  lmsc_pkg::lmsc_req_t   req,
  input  lmsc_pkg::lmsc_qstat_t qstat,
  output logic                  busy,
  output logic                  push,
  output lmsc_pkg::lmsc_op_t    push_op
);

  localparam int PosW = lmsc_pkg::POS_W;
  localparam int GW   = lmsc_pkg::GLYPH_ROWS * lmsc_pkg::GLYPH_COLS;

  logic               fr_valid_r;
  logic               fr_valid_nxt;
  lmsc_pkg::lmsc_op_t fr_op_r;
  lmsc_pkg::lmsc_op_t dec_op;
  logic               accept;
  logic [GW-1:0]      glyph;
  logic [PosW-1:0]    colx;

  assign busy         = fr_valid_r && qstat.full;
  assign push         = fr_valid_r && !qstat.full;
  assign push_op      = fr_op_r;
  assign accept       = start && !busy;
  assign fr_valid_nxt = accept || (fr_valid_r && qstat.full);
  assign glyph        = lmsc_pkg::glyph_bits(req.digit);
  assign colx         = PosW'(req.column);

  always_comb begin
    dec_op          = '0;
    dec_op.kind     = lmsc_pkg::OP_NOP;
    dec_op.base_row = req.row;
    dec_op.letter   = req.letter;
    case (lmsc_pkg::lmsc_cmd_t'(req.command))
      lmsc_pkg::CMD_TICK: begin
        dec_op.kind = lmsc_pkg::OP_TICK;
      end
      lmsc_pkg::CMD_PIXEL: begin
        dec_op.kind = req.pixel_value ? lmsc_pkg::OP_SET : lmsc_pkg::OP_CLEAR_PX;
        // columns off the matrix leave the mask empty
        for (int b = 0; b < MATRIX_SIZE; b++) begin
          dec_op.masks[0][b] = (colx == PosW'(MATRIX_SIZE - b));
        end
      end
      lmsc_pkg::CMD_CLEAR: begin
        dec_op.kind = lmsc_pkg::OP_BLANK;
      end
      lmsc_pkg::CMD_DIGIT: begin
        dec_op.kind = lmsc_pkg::OP_SET;
        for (int dy = 0; dy < lmsc_pkg::GLYPH_ROWS; dy++) begin
          for (int dx = 0; dx < lmsc_pkg::GLYPH_COLS; dx++) begin
            for (int b = 0; b < MATRIX_SIZE; b++) begin
              if (glyph[GW-1-lmsc_pkg::GLYPH_COLS*dy-dx] &&
                  (colx + PosW'(dx) == PosW'(MATRIX_SIZE - b))) begin
                dec_op.masks[dy][b] = 1'b1;
              end
            end
          end
        end
      end
      lmsc_pkg::CMD_LETTER: begin
        dec_op.kind = lmsc_pkg::OP_LETTER;
      end
      default: begin
        dec_op.kind = lmsc_pkg::OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_op_r <= dec_op;
    end
  end

endmodule

[rtl/core/lmsc_queue.sv]
// Short queue of decoded requests between front and back ends.
// Depends on lmsc_pkg.
module lmsc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lmsc_pkg::lmsc_op_t    push_op,
  input  logic                  pop,
  output lmsc_pkg::lmsc_op_t    pop_op,
  output lmsc_pkg::lmsc_qstat_t qstat
);

  localparam int Depth = lmsc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lmsc_pkg::lmsc_op_t mem_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r;
  logic [PtrW-1:0]    wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r;
  logic [PtrW-1:0]    rd_ptr_nxt;
  logic [CntW-1:0]    count_r;
  logic [CntW-1:0]    count_nxt;
  logic               do_push;
  logic               do_pop;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CntW'(Depth));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_op      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[rtl/core/lmsc_back.sv]
// Back end: frame buffer, row scan counters and the registered result.
// Depends on lmsc_pkg.
module lmsc_back #(
  parameter int MATRIX_SIZE = lmsc_pkg::MATRIX_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lmsc_pkg::lmsc_qstat_t         qstat,
  input  lmsc_pkg::lmsc_op_t            op,
  output logic                          pop,
  input  logic                          cfg_we,
  input  logic [lmsc_pkg::DWELL_W-1:0]  cfg_data,
  output logic                          out_valid,
  output lmsc_pkg::lmsc_res_t           out_res
);

  localparam int RW   = $clog2(MATRIX_SIZE);
  localparam int PosW = lmsc_pkg::POS_W;
  localparam int DW   = lmsc_pkg::DWELL_W;
  localparam int MaxW = lmsc_pkg::MAX_SIZE;
  localparam int ExtW = lmsc_pkg::ROW_W;

  logic [MATRIX_SIZE-1:0] fb_r   [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] fb_nxt [MATRIX_SIZE];
  logic [RW-1:0]          ar_r;
  logic [RW-1:0]          ar_nxt;
  logic [DW-1:0]          dwell_r;
  logic [DW-1:0]          dwell_nxt;
  logic [DW-1:0]          row_dwell_r;
  logic                   out_valid_r;
  lmsc_pkg::lmsc_res_t    out_res_r;
  lmsc_pkg::lmsc_res_t    res_nxt;
  logic [MaxW-1:0]        lrow;
  logic [MaxW-1:0]        cur_row;
  logic                   hit;

  assign pop       = !qstat.empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    fb_nxt    = fb_r;
    ar_nxt    = ar_r;
    dwell_nxt = dwell_r;
    lrow      = '0;
    hit       = 1'b0;
    if (pop) begin
      case (op.kind)
        lmsc_pkg::OP_TICK: begin
          if ({1'b0, dwell_r} + (DW + 1)'(1) >= {1'b0, row_dwell_r}) begin
            dwell_nxt = '0;
            ar_nxt    = (ar_r == RW'(MATRIX_SIZE - 1)) ? '0 : ar_r + 1'b1;
          end else begin
            dwell_nxt = dwell_r + 1'b1;
          end
        end
        lmsc_pkg::OP_SET: begin
          for (int i = 0; i < MATRIX_SIZE; i++) begin
            for (int dy = 0; dy < lmsc_pkg::GLYPH_ROWS; dy++) begin
              hit = (PosW'(op.base_row) + PosW'(dy) == PosW'(i + 1));
              if (hit) begin
                fb_nxt[i] = fb_nxt[i] | op.masks[dy][MATRIX_SIZE-1:0];
              end
            end
          end
        end
        lmsc_pkg::OP_CLEAR_PX: begin
          for (int i = 0; i < MATRIX_SIZE; i++) begin
            hit = (PosW'(op.base_row) == PosW'(i + 1));
            if (hit) begin
              fb_nxt[i] = fb_r[i] & ~op.masks[0][MATRIX_SIZE-1:0];
            end
          end
        end
        lmsc_pkg::OP_BLANK: begin
          for (int i = 0; i < MATRIX_SIZE; i++) begin
            fb_nxt[i] = '0;
          end
        end
        lmsc_pkg::OP_LETTER: begin
          for (int i = 0; i < MATRIX_SIZE; i++) begin
            lrow      = lmsc_pkg::letter_row(op.letter, i + 1, MATRIX_SIZE);
            fb_nxt[i] = lrow[MATRIX_SIZE-1:0];
          end
        end
        default: begin
          fb_nxt = fb_r;
        end
      endcase
    end
  end

  // Result shows the scanned row after the request has taken effect.
  always_comb begin
    cur_row              = MaxW'(fb_nxt[ar_nxt]);
    res_nxt.column_data  = cur_row[7:0];
    res_nxt.scan_row     = ExtW'(ar_nxt) < ExtW'(8) ? 3'(ar_nxt) : 3'(ar_nxt);
    for (int k = 0; k < 8; k++) begin
      res_nxt.row_select_n[k] = !(ExtW'(ar_nxt) == ExtW'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MATRIX_SIZE; i++) begin
        fb_r[i] <= '0;
      end
      ar_r        <= '0;
      dwell_r     <= '0;
      row_dwell_r <= DW'(1);
      out_valid_r <= 1'b0;
    end else begin
      fb_r        <= fb_nxt;
      ar_r        <= ar_nxt;
      dwell_r     <= dwell_nxt;
      out_valid_r <= pop;
      if (cfg_we) begin
        row_dwell_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

[tb/tb_led_matrix_scan_controller.sv]
// Self-checking bench for led_matrix_scan_controller: drives commands, tracks the frame buffer
// and scan state in its own model, and compares every result the block reports.
// Depends on lmsc_pkg and led_matrix_scan_controller.
module tb_led_matrix_scan_controller;
  import lmsc_pkg::*;

  localparam int N = 8;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic       LETTER_S        = 1'b0;
  localparam logic       LETTER_T        = 1'b1;
  localparam int         PHASE_COUNT     = 8;
  localparam int         PHASE_ITEMS     = 94;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  lmsc_req_t       in_req    = '0;
  logic            out_valid;
  lmsc_res_t       out_res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [15:0]     cfg_data  = '0;

  // Expected scan state
  logic [N-1:0]    frame_rows [N];
  logic [2:0]      scan_pos;
  logic [15:0]     dwell_cnt;
  logic [15:0]     dwell_limit;

  lmsc_req_t       pending_q [$];
  lmsc_res_t       scan_expect_q [$];
  int              idle_pct   = 0;
  logic            drain_wait = 1'b0;
  int              mismatch_count = 0;

  led_matrix_scan_controller #(.MATRIX_SIZE(N)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // 3x5 font, glyph row 0 in bits 14:12, left column in the high bit of each row
  function automatic logic [14:0] digit_font(logic [3:0] d);
    case (d)
      4'd0:    return 15'b111_101_101_101_111;
      4'd1:    return 15'b001_011_001_001_001;
      4'd2:    return 15'b111_001_111_100_111;
      4'd3:    return 15'b111_001_111_001_111;
      4'd4:    return 15'b101_101_111_001_001;
      4'd5:    return 15'b111_100_111_001_111;
      4'd6:    return 15'b111_100_111_101_111;
      4'd7:    return 15'b111_001_001_001_001;
      4'd8:    return 15'b111_101_111_101_111;
      4'd9:    return 15'b111_101_111_001_111;
      default: return '0;
    endcase
  endfunction

  function automatic void light(logic on, int col, int rw);
    if (col < 1 || col > N || rw < 1 || rw > N) return;
    frame_rows[rw-1][N-col] = on;
  endfunction

  function automatic void blank_frame();
    for (int i = 0; i < N; i++) frame_rows[i] = '0;
  endfunction

  function automatic void draw_letter(logic which);
    blank_frame();
    for (int i = 2; i + 1 <= N; i++) begin
      if (which == LETTER_S) begin
        light(1'b1, i, 1);
        light(1'b1, i, 2);
        light(1'b1, i, 4);
        light(1'b1, i, 5);
        light(1'b1, i, 7);
        light(1'b1, i, 8);
      end else begin
        light(1'b1, i, 2);
        light(1'b1, i, 3);
        light(1'b1, 4, i);
        light(1'b1, 5, i);
      end
    end
    if (which == LETTER_S) begin
      light(1'b1, 2, 3);
      light(1'b1, 3, 3);
      light(1'b1, 6, 6);
      light(1'b1, 7, 6);
    end
  endfunction

  // Apply one command to the expected state and return the row it leaves on the outputs
  function automatic lmsc_res_t scan_model_apply(lmsc_req_t r);
    lmsc_res_t   e;
    logic [14:0] g;
    case (r.command)
      CMD_TICK: begin
        if (int'(dwell_cnt) + 1 >= int'(dwell_limit)) begin
          dwell_cnt = '0;
          scan_pos  = (scan_pos == N - 1) ? 3'd0 : scan_pos + 3'd1;
        end else begin
          dwell_cnt = dwell_cnt + 16'd1;
        end
      end
      CMD_PIXEL: light(r.pixel_value, int'(r.column), int'(r.row));
      CMD_CLEAR: blank_frame();
      CMD_DIGIT: begin
        if (r.digit <= 4'd9) begin
          g = digit_font(r.digit);
          for (int dy = 0; dy < 5; dy++)
            for (int dx = 0; dx < 3; dx++)
              if (g[14 - 3*dy - dx]) light(1'b1, int'(r.column) + dx, int'(r.row) + dy);
        end
      end
      CMD_LETTER: draw_letter(r.letter);
      default: ;
    endcase
    e.row_select_n = ~(8'd1 << scan_pos);
    e.column_data  = frame_rows[scan_pos];
    e.scan_row     = scan_pos;
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) scan_expect_q.push_back(scan_model_apply(in_req));
      if (!start || !busy) begin
        if (drain_wait) begin
          start <= 1'b0;
          if (scan_expect_q.size() == 0) drain_wait <= 1'b0;
        end else if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          in_req <= pending_q.pop_front();
          if ($urandom_range(149) == 0) drain_wait <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    lmsc_res_t e;
    if (rst_n && out_valid) begin
      if (scan_expect_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_res), 0);
      end else begin
        e = scan_expect_q.pop_front();
        if (out_res.row_select_n !== e.row_select_n)
          report_mismatch("row_select_n", int'(out_res.row_select_n), int'(e.row_select_n));
        if (out_res.column_data !== e.column_data)
          report_mismatch("column_data", int'(out_res.column_data), int'(e.column_data));
        if (out_res.scan_row !== e.scan_row)
          report_mismatch("scan_row", int'(out_res.scan_row), int'(e.scan_row));
      end
    end
  end

  task automatic queue_item(logic [2:0] cmd, logic val, int col, int rw, int dig, logic ltr);
    lmsc_req_t r;
    r.command     = cmd;
    r.pixel_value = val;
    r.column      = col[3:0];
    r.row         = rw[3:0];
    r.digit       = dig[3:0];
    r.letter      = ltr;
    pending_q.push_back(r);
  endtask

  function automatic lmsc_req_t random_cmd();
    lmsc_req_t r;
    int        pick;
    pick          = $urandom_range(99);
    r.pixel_value = 1'($urandom_range(1));
    r.letter      = 1'($urandom_range(1));
    r.digit       = 4'($urandom_range(15));
    if (pick < 35)      r.command = CMD_TICK;
    else if (pick < 60) r.command = CMD_PIXEL;
    else if (pick < 77) r.command = CMD_DIGIT;
    else if (pick < 82) r.command = CMD_CLEAR;
    else if (pick < 94) r.command = CMD_LETTER;
    else                r.command = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    if (r.command == CMD_DIGIT && $urandom_range(99) < 80) r.digit = 4'($urandom_range(9));
    // keep most positions on the matrix, the rest anywhere the field allows
    if ($urandom_range(99) < 85) begin
      r.column = 4'($urandom_range(N, 1));
      r.row    = 4'($urandom_range(N, 1));
    end else begin
      r.column = 4'($urandom_range(15));
      r.row    = 4'($urandom_range(15));
    end
    return r;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || scan_expect_q.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_dwell(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    dwell_limit = v;
  endtask

  initial begin : stimulus
    logic [15:0] dwell_plan [PHASE_COUNT];
    blank_frame();
    scan_pos    = '0;
    dwell_cnt   = '0;
    dwell_limit = 16'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 21;
    queue_item(CMD_PIXEL, 1'b1, 1, 1, 0, LETTER_S);
    queue_item(CMD_PIXEL, 1'b1, 8, 1, 0, LETTER_S);
    queue_item(CMD_PIXEL, 1'b1, 8, 8, 0, LETTER_S);
    queue_item(CMD_PIXEL, 1'b0, 1, 1, 0, LETTER_S);
    // off-matrix writes are clipped
    queue_item(CMD_PIXEL, 1'b1, 0, 1, 0, LETTER_S);
    queue_item(CMD_PIXEL, 1'b1, 9, 1, 0, LETTER_T);
    queue_item(CMD_PIXEL, 1'b1, 15, 15, 15, LETTER_T);
    queue_item(CMD_PIXEL, 1'b1, 3, 0, 0, LETTER_S);
    queue_item(CMD_DIGIT, 1'b0, 1, 1, 8, LETTER_S);
    queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    queue_item(CMD_DIGIT, 1'b1, 7, 5, 0, LETTER_T);
    queue_item(CMD_DIGIT, 1'b0, 2, 2, 10, LETTER_S);
    queue_item(CMD_DIGIT, 1'b0, 2, 2, 15, LETTER_S);
    queue_item(CMD_CLEAR, 1'b1, 15, 15, 15, LETTER_T);
    queue_item(CMD_LETTER, 1'b0, 1, 1, 0, LETTER_S);
    queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    queue_item(CMD_LETTER, 1'b0, 1, 1, 0, LETTER_T);
    queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    queue_item(CMD_SPARE_FIRST, 1'b1, 2, 2, 3, LETTER_T);
    queue_item(CMD_SPARE_LAST, 1'b1, 5, 5, 8, LETTER_S);
    queue_item(CMD_CLEAR, 1'b0, 1, 1, 0, LETTER_S);
    wait_drained();

    // raise the dwell, then lower it below the running count: the next tick after that must advance
    write_dwell(16'd6);
    @(negedge clk);
    repeat (4) queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    wait_drained();
    write_dwell(16'd2);
    @(negedge clk);
    repeat (2) queue_item(CMD_TICK, 1'b0, 1, 1, 0, LETTER_S);
    wait_drained();

    dwell_plan = '{16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd3, 16'd0, 16'd4, 16'd0};
    dwell_plan[5] = 16'($urandom_range(12, 1));
    dwell_plan[7] = 16'($urandom);
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_dwell(dwell_plan[p]);
      @(negedge clk);
      idle_pct = (p < 3) ? 21 : (p < 6) ? 77 : 0;
      repeat (PHASE_ITEMS) pending_q.push_back(random_cmd());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
